/* hdl/first_order_hold_vector_interp_core_macros.svh */
// Assertion macros used by the checker file.
`ifndef FIRST_ORDER_HOLD_VECTOR_INTERP_CORE_MACROS_SVH
`define FIRST_ORDER_HOLD_VECTOR_INTERP_CORE_MACROS_SVH

// Property checked while out of reset.
`define FOHV_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("fohv: property violated");

// Property checked at every edge, reset included.
`define FOHV_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("fohv: property violated");

`endif

/* hdl/fohv_pkg.sv */
// Shared types, constants and helpers of the first-order hold core.
`default_nettype none
package fohv_pkg;

    localparam int TIME_W    = 32;
    localparam int VEC_W     = 32;
    localparam int AXES      = 3;
    localparam int AX_W      = 2;
    localparam int MAG_W     = 63;
    localparam int DIV_STEPS = 32;
    localparam int MUL_STEPS = 4 * AXES;
    localparam int CNT_W     = 5;
    localparam int SUM_W     = 64;
    localparam int INT_W     = 43;
    localparam int MODE_W    = 2;
    localparam int CODE_W    = 3;
    localparam int S_DATA_W  = 2 * TIME_W + AXES * VEC_W;
    localparam int M_DATA_W  = AXES * VEC_W;

    localparam logic [SUM_W-1:0] VAL_LIM = 64'h0000_0100_0000_0000;

    localparam logic [MODE_W-1:0] MODE_UPDATE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACTIVATE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEACTIVATE = 2'd2;

    localparam logic [CODE_W-1:0] CASE_INACTIVE = 3'd0;
    localparam logic [CODE_W-1:0] CASE_FAST     = 3'd1;
    localparam logic [CODE_W-1:0] CASE_LAG      = 3'd2;
    localparam logic [CODE_W-1:0] CASE_INTERP   = 3'd3;
    localparam logic [CODE_W-1:0] CASE_SNAP     = 3'd4;
    localparam logic [CODE_W-1:0] CASE_HOLD     = 3'd5;

    typedef logic [AXES-1:0][VEC_W-1:0] vec3_t;

    typedef enum logic [2:0] {
        K_PASS, K_ACT, K_DEACT, K_FAST, K_LAG, K_INTERP, K_SNAP, K_HOLD
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_DIV, ST_MUL, ST_DONE
    } ctl_state_t;

    typedef enum logic [1:0] {
        PH_HI, PH_LO, PH_SUM, PH_FIN
    } mul_phase_t;

    typedef struct packed {
        logic             accept;
        logic             div_init;
        logic             div_step;
        logic             mul_en;
        mul_phase_t       phase;
        logic [AX_W-1:0]  axis;
        logic             commit;
    } ctl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  out_busy;
    } dp_stat_t;

    function automatic logic [VEC_W-1:0] sat_vec(input logic signed [INT_W-1:0] v);
        logic signed [INT_W-1:0] hi;
        logic signed [INT_W-1:0] lo;
        hi = INT_W'(signed'({1'b0, {(VEC_W-1){1'b1}}}));
        lo = -hi - INT_W'(1);
        if (v > hi) begin
            return hi[VEC_W-1:0];
        end else if (v < lo) begin
            return lo[VEC_W-1:0];
        end
        return v[VEC_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* hdl/fohv_ctrl.sv */
// Controller: sequences accept, slope division, interpolation and commit.
`default_nettype none
module fohv_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire fohv_pkg::dp_stat_t stat,
    output fohv_pkg::ctl_cmd_t      cmd
);
    import fohv_pkg::*;

    ctl_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cnt_next = '0;
                if (stat.kind == K_LAG) begin
                    state_next = ST_DIV;
                end else if (stat.kind == K_INTERP) begin
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) state_next = ST_DONE;
            end
            ST_MUL: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MUL_STEPS - 1)) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!stat.out_busy) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                // hold off transfers while in reset
                s_tready   = aresetn;
                cmd.accept = s_tvalid && aresetn;
            end
            ST_LOAD: cmd.div_init = (stat.kind == K_LAG);
            ST_DIV:  cmd.div_step = 1'b1;
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                cmd.phase  = mul_phase_t'(cnt_reg[1:0]);
                cmd.axis   = cnt_reg[AX_W+1:2];
            end
            ST_DONE: cmd.commit = !stat.out_busy;
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

/* hdl/fohv_dp.sv */
// Datapath: hold state, slope dividers, shared multiplier and output register.
`default_nettype none
module fohv_dp (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic                            cfg_wr_data,
    input  wire logic [fohv_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire logic [fohv_pkg::MODE_W-1:0]     s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [fohv_pkg::M_DATA_W-1:0]        m_tdata,
    output logic [fohv_pkg::CODE_W-1:0]          m_tuser,
    input  wire fohv_pkg::ctl_cmd_t              cmd,
    output fohv_pkg::dp_stat_t                   stat
);
    import fohv_pkg::*;

    // architectural state
    logic                 hold_en_reg;
    logic                 armed_reg;
    logic [TIME_W-1:0]    ref_time_reg;
    logic [TIME_W-1:0]    last_visit_reg;
    logic [TIME_W-1:0]    span_reg;
    vec3_t                ref_vec_reg;
    vec3_t                start_vec_reg;
    vec3_t                last_out_reg;
    logic [MAG_W-1:0]     slope_mag_reg [AXES];
    logic [AXES-1:0]      slope_neg_reg;

    // item registers
    kind_t                kind_reg, kind_next;
    logic [TIME_W-1:0]    now_reg;
    logic [TIME_W-1:0]    stamp_reg;
    logic [TIME_W-1:0]    new_span_reg;
    logic [TIME_W-1:0]    dt_reg;
    vec3_t                vin_reg;

    // divider lanes
    logic [TIME_W-1:0]    rem_reg [AXES];
    logic [TIME_W-1:0]    rem_next [AXES];
    logic [2*TIME_W-1:0]  dq_reg [AXES];
    logic [2*TIME_W-1:0]  dq_next [AXES];
    logic [AXES-1:0]      dneg_reg;

    // interpolation
    logic [SUM_W-1:0]     mul_reg;
    logic [SUM_W-1:0]     acc_reg;
    logic [SUM_W-1:0]     sum_reg;
    vec3_t                res_reg;

    logic                 out_valid_reg;
    logic [M_DATA_W-1:0]  out_data_reg;
    logic [CODE_W-1:0]    out_code_reg;

    logic [TIME_W-1:0]    in_now, in_stamp;
    vec3_t                in_vec;
    logic [TIME_W-1:0]    since_visit, in_span, in_dt;
    vec3_t                out_vec;
    logic [CODE_W-1:0]    out_code;
    logic [TIME_W-1:0]    mul_op;
    logic [INT_W-2:0]     val_clamped;
    logic signed [INT_W-1:0] start_ext, interp_sum;

    assign in_now      = s_tdata[TIME_W-1:0];
    assign in_stamp    = s_tdata[2*TIME_W-1:TIME_W];
    assign in_vec      = s_tdata[S_DATA_W-1:2*TIME_W];
    assign since_visit = in_now - last_visit_reg;
    assign in_span     = in_stamp - ref_time_reg;
    assign in_dt       = in_now - ref_time_reg;

    always_comb begin
        kind_next = K_PASS;
        if (s_tuser == MODE_ACTIVATE) begin
            kind_next = K_ACT;
        end else if (s_tuser == MODE_DEACTIVATE) begin
            kind_next = K_DEACT;
        end else if (s_tuser == MODE_UPDATE && hold_en_reg && armed_reg) begin
            if (in_stamp != ref_time_reg) begin
                kind_next = (since_visit >= in_span) ? K_FAST : K_LAG;
            end else if (in_dt < span_reg) begin
                kind_next = K_INTERP;
            end else if (span_reg != '0) begin
                kind_next = K_SNAP;
            end else begin
                kind_next = K_HOLD;
            end
        end
    end

    // two restoring steps per cycle on each lane
    always_comb begin
        logic [TIME_W:0] r1;
        logic [TIME_W:0] r2;
        logic            b1;
        logic            b2;
        for (int i = 0; i < AXES; i++) begin
            r1 = {rem_reg[i], dq_reg[i][2*TIME_W-1]};
            b1 = (r1 >= {1'b0, new_span_reg});
            if (b1) r1 = r1 - {1'b0, new_span_reg};
            r2 = {r1[TIME_W-1:0], dq_reg[i][2*TIME_W-2]};
            b2 = (r2 >= {1'b0, new_span_reg});
            if (b2) r2 = r2 - {1'b0, new_span_reg};
            rem_next[i] = r2[TIME_W-1:0];
            dq_next[i]  = {dq_reg[i][2*TIME_W-3:0], b1, b2};
        end
    end

    assign mul_op = (cmd.phase == PH_HI) ? {1'b0, slope_mag_reg[cmd.axis][MAG_W-1:TIME_W]}
                                         : slope_mag_reg[cmd.axis][TIME_W-1:0];
    assign val_clamped = (sum_reg > VAL_LIM) ? VAL_LIM[INT_W-2:0] : sum_reg[INT_W-2:0];
    assign start_ext   = INT_W'(signed'(start_vec_reg[cmd.axis]));
    assign interp_sum  = slope_neg_reg[cmd.axis]
                         ? start_ext - signed'({1'b0, val_clamped})
                         : start_ext + signed'({1'b0, val_clamped});

    always_comb begin
        out_vec  = vin_reg;
        out_code = CASE_INACTIVE;
        case (kind_reg)
            K_FAST:   out_code = CASE_FAST;
            K_LAG: begin
                out_vec  = ref_vec_reg;
                out_code = CASE_LAG;
            end
            K_INTERP: begin
                out_vec  = res_reg;
                out_code = CASE_INTERP;
            end
            K_SNAP: begin
                out_vec  = ref_vec_reg;
                out_code = CASE_SNAP;
            end
            K_HOLD: begin
                out_vec  = last_out_reg;
                out_code = CASE_HOLD;
            end
            default: out_code = CASE_INACTIVE;
        endcase
    end

    // item capture and working registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            kind_reg     <= kind_next;
            now_reg      <= in_now;
            stamp_reg    <= in_stamp;
            new_span_reg <= in_span;
            dt_reg       <= in_dt;
            vin_reg      <= in_vec;
        end
        for (int i = 0; i < AXES; i++) begin
            if (cmd.div_init) begin
                logic signed [VEC_W:0] d;
                d = signed'({vin_reg[i][VEC_W-1], vin_reg[i]})
                    - signed'({ref_vec_reg[i][VEC_W-1], ref_vec_reg[i]});
                dneg_reg[i] <= d[VEC_W];
                dq_reg[i]   <= {(d[VEC_W] ? VEC_W'(-d) : d[VEC_W-1:0]), {TIME_W{1'b0}}};
                rem_reg[i]  <= '0;
            end else if (cmd.div_step) begin
                dq_reg[i]  <= dq_next[i];
                rem_reg[i] <= rem_next[i];
            end
        end
        if (cmd.mul_en) begin
            case (cmd.phase)
                PH_HI:  mul_reg <= mul_op * dt_reg;
                PH_LO: begin
                    acc_reg <= mul_reg;
                    mul_reg <= mul_op * dt_reg;
                end
                PH_SUM: sum_reg <= acc_reg + {{TIME_W{1'b0}}, mul_reg[SUM_W-1:TIME_W]};
                PH_FIN: res_reg[cmd.axis] <= sat_vec(interp_sum);
                default: sum_reg <= sum_reg;
            endcase
        end
        if (cmd.commit) begin
            out_data_reg <= out_vec;
            out_code_reg <= out_code;
        end
    end

    // architectural state and output handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_en_reg    <= 1'b0;
            armed_reg      <= 1'b0;
            ref_time_reg   <= '0;
            last_visit_reg <= '0;
            span_reg       <= '0;
            ref_vec_reg    <= '0;
            start_vec_reg  <= '0;
            last_out_reg   <= '0;
            slope_neg_reg  <= '0;
            for (int i = 0; i < AXES; i++) slope_mag_reg[i] <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) hold_en_reg <= cfg_wr_data;
            if (m_tready && !cmd.commit) out_valid_reg <= 1'b0;
            if (cmd.commit) begin
                out_valid_reg <= 1'b1;
                last_out_reg  <= out_vec;
                case (kind_reg)
                    K_ACT: begin
                        ref_time_reg <= now_reg;
                        ref_vec_reg  <= vin_reg;
                        armed_reg    <= 1'b1;
                    end
                    K_DEACT: armed_reg <= 1'b0;
                    K_FAST: begin
                        ref_time_reg   <= stamp_reg;
                        start_vec_reg  <= ref_vec_reg;
                        ref_vec_reg    <= vin_reg;
                        span_reg       <= '0;
                        slope_neg_reg  <= '0;
                        for (int i = 0; i < AXES; i++) slope_mag_reg[i] <= '0;
                        last_visit_reg <= now_reg;
                    end
                    K_LAG: begin
                        ref_time_reg   <= stamp_reg;
                        start_vec_reg  <= ref_vec_reg;
                        ref_vec_reg    <= vin_reg;
                        span_reg       <= new_span_reg;
                        slope_neg_reg  <= dneg_reg;
                        // saturate when the integer part overflows
                        for (int i = 0; i < AXES; i++) begin
                            slope_mag_reg[i] <= dq_reg[i][2*TIME_W-1] ? {MAG_W{1'b1}}
                                                                      : dq_reg[i][MAG_W-1:0];
                        end
                        last_visit_reg <= now_reg;
                    end
                    K_SNAP: begin
                        span_reg       <= '0;
                        last_visit_reg <= now_reg;
                    end
                    K_INTERP, K_HOLD: last_visit_reg <= now_reg;
                    default: armed_reg <= armed_reg;
                endcase
            end
        end
    end

    assign stat.kind     = kind_reg;
    assign stat.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_data_reg;
    assign m_tuser       = out_code_reg;

endmodule
`default_nettype wire

/* hdl/first_order_hold_vector_interp_core.sv */
// Sequencing: pass, activate, deactivate, fast, snap and hold items go from load straight to commit;
// a new sample that needs a slope first runs the slope division (two quotient bits a cycle on each
// axis divider), and interpolation runs its steps on one shared 32x32 multiplier.
// Items are taken one at a time; a waiting result blocks the next item.
// Reset: aresetn, synchronous active low, clears all hold state and hold_enable.
`default_nettype none
module first_order_hold_vector_interp_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_wr_data,   // hold_enable
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [fohv_pkg::S_DATA_W-1:0] s_tdata,  // now_time, sample_time, in_x, in_y, in_z
    input  wire logic [fohv_pkg::MODE_W-1:0]   s_tuser,  // mode
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [fohv_pkg::M_DATA_W-1:0]      m_tdata,  // out_x, out_y, out_z
    output logic [fohv_pkg::CODE_W-1:0]        m_tuser   // case_code
);
    import fohv_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    fohv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fohv_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule
`default_nettype wire

/* hdl/fohv_chk.sv */
// Port-level checker for the first-order hold core, bound to the top level.
`default_nettype none
`include "first_order_hold_vector_interp_core_macros.svh"
module fohv_chk (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          cfg_wr_en,
    input wire logic                          cfg_wr_data,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [fohv_pkg::S_DATA_W-1:0] s_tdata,
    input wire logic [fohv_pkg::MODE_W-1:0]   s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [fohv_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic [fohv_pkg::CODE_W-1:0]   m_tuser
);
    import fohv_pkg::*;

    `FOHV_ASSERT(a_one_at_a_time, (s_tvalid && s_tready) |=> !s_tready)
    `FOHV_ASSERT(a_no_instant_result, (s_tvalid && s_tready) |=> !$rose(m_tvalid))
    `FOHV_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    `FOHV_ASSERT_ALWAYS(a_reset_empty, $past(!aresetn) |-> !m_tvalid)

endmodule

bind first_order_hold_vector_interp_core fohv_chk u_fohv_chk (.*);
`default_nettype wire

/* verif/tb_first_order_hold_vector_interp_core.sv */
// Testbench for the first-order hold core: random and directed streams checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_first_order_hold_vector_interp_core;
    import fohv_pkg::*;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [31:0]       now_t;
        logic [31:0]       stamp;
        logic [31:0]       v [3];
    } hold_item_t;

    typedef struct {
        logic [31:0]       v [3];
        logic [CODE_W-1:0] code;
    } hold_out_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic cfg_wr_data = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [MODE_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [CODE_W-1:0] m_tuser;

    first_order_hold_vector_interp_core u_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // predictor state
    logic        hold_en;
    logic        armed;
    logic [31:0] ref_t, visit_t, span;
    logic signed [31:0] ref_v [3], start_v [3], last_v [3];
    logic [63:0] slope [3];

    hold_item_t pending_items[$];
    hold_out_t  expected_outs[$];
    int mismatches = 0;
    bit timed_out = 0;

    function automatic logic [63:0] slope_mag(input logic [63:0] mag, input logic [31:0] d);
        logic [63:0] q, r, frac;
        q = mag / d;
        r = mag % d;
        frac = 0;
        if (q >= 64'h8000_0000) return 64'h7FFF_FFFF_FFFF_FFFF;
        for (int i = 0; i < 32; i++) begin
            r = r << 1;
            frac = frac << 1;
            if (r >= d) begin
                r = r - d;
                frac[0] = 1'b1;
            end
        end
        return (q << 32) | frac;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
        if (v < -64'sh8000_0000) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] ramp_value(input logic signed [31:0] st,
                                                      input logic [63:0] sl,
                                                      input logic [31:0] dt);
        logic neg;
        logic [63:0] mag;
        logic [127:0] prod;
        logic [63:0] val;
        neg = sl[63];
        mag = neg ? -sl : sl;
        prod = mag * {96'd0, dt};
        val = prod[95:32];
        if (prod[127:96] != 0 || val > 64'h100_0000_0000) val = 64'h100_0000_0000;
        return neg ? sat32(64'(st) - signed'(val)) : sat32(64'(st) + signed'(val));
    endfunction

    function automatic hold_out_t predict_hold(input hold_item_t it);
        hold_out_t o;
        logic [31:0] since, d, dt;
        logic signed [32:0] diff;
        logic [63:0] m;
        for (int i = 0; i < 3; i++) o.v[i] = it.v[i];
        o.code = CASE_INACTIVE;
        if (it.mode == MODE_ACTIVATE) begin
            ref_t = it.now_t;
            for (int i = 0; i < 3; i++) ref_v[i] = it.v[i];
            armed = 1;
        end else if (it.mode == MODE_DEACTIVATE) begin
            armed = 0;
        end else if (it.mode == MODE_UPDATE && hold_en && armed) begin
            if (it.stamp != ref_t) begin
                since = it.now_t - visit_t;
                d = it.stamp - ref_t;
                ref_t = it.stamp;
                for (int i = 0; i < 3; i++) start_v[i] = ref_v[i];
                if (since >= d) begin
                    for (int i = 0; i < 3; i++) begin
                        ref_v[i] = it.v[i];
                        slope[i] = 0;
                    end
                    span = 0;
                    o.code = CASE_FAST;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        diff = 33'(signed'(it.v[i])) - 33'(ref_v[i]);
                        m = slope_mag(diff < 0 ? 64'(-diff) : 64'(diff), d);
                        slope[i] = diff < 0 ? -m : m;
                        o.v[i] = ref_v[i];
                        ref_v[i] = it.v[i];
                    end
                    span = d;
                    o.code = CASE_LAG;
                end
            end else begin
                dt = it.now_t - ref_t;
                if (dt < span) begin
                    for (int i = 0; i < 3; i++) o.v[i] = ramp_value(start_v[i], slope[i], dt);
                    o.code = CASE_INTERP;
                end else if (span != 0) begin
                    for (int i = 0; i < 3; i++) o.v[i] = ref_v[i];
                    span = 0;
                    o.code = CASE_SNAP;
                end else begin
                    for (int i = 0; i < 3; i++) o.v[i] = last_v[i];
                    o.code = CASE_HOLD;
                end
            end
            visit_t = it.now_t;
        end
        for (int i = 0; i < 3; i++) last_v[i] = o.v[i];
        return o;
    endfunction

    // driver
    int s_gap = 0;
    always @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            expected_outs.push_back(predict_hold(pending_items.pop_front()));
        end
        if (s_tvalid && !s_tready) begin
            // hold the current transfer
        end else if (s_gap > 0) begin
            s_gap <= s_gap - 1;
            s_tvalid <= 1'b0;
        end else if (pending_items.size() > (s_tvalid && s_tready ? 0 : 0) && aresetn) begin
            s_tvalid <= 1'b1;
            s_tuser <= pending_items[0].mode;
            s_tdata <= {pending_items[0].v[2], pending_items[0].v[1], pending_items[0].v[0],
                        pending_items[0].stamp, pending_items[0].now_t};
            s_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // monitor
    int m_gap = 0;
    always @(posedge aclk) begin
        hold_out_t e;
        if (m_tvalid && m_tready) begin
            if (expected_outs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h code %0d", m_tdata, m_tuser);
            end else begin
                e = expected_outs.pop_front();
                if (m_tdata != {e.v[2], e.v[1], e.v[0]} || m_tuser != e.code) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h %h %h code %0d, got %h code %0d",
                                 e.v[0], e.v[1], e.v[2], e.code, m_tdata, m_tuser);
                end
            end
        end
        if (m_gap > 0) begin
            m_gap <= m_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (m_tvalid && m_tready) m_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        end
    end

    function automatic logic [31:0] rand_vec();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
            default: return $urandom();
        endcase
    endfunction

    logic [31:0] clk_now, clk_stamp;

    task automatic queue_item(input logic [MODE_W-1:0] md, input logic [31:0] nt,
                              input logic [31:0] st);
        hold_item_t it;
        it.mode = md;
        it.now_t = nt;
        it.stamp = st;
        for (int i = 0; i < 3; i++) it.v[i] = rand_vec();
        pending_items.push_back(it);
    endtask

    // one slow sample period stepped in fast ticks, random content
    task automatic queue_sample_run();
        logic [31:0] period;
        int ticks;
        period = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(1, 40);
        ticks = $urandom_range(1, 6);
        clk_stamp = clk_stamp + period;
        for (int k = 0; k < ticks; k++) begin
            clk_now = clk_now + $urandom_range(0, 20);
            queue_item(MODE_UPDATE, clk_now, clk_stamp);
        end
    endtask

    task automatic drain_and_set(input logic en);
        wait (pending_items.size() == 0 && !s_tvalid && expected_outs.size() == 0);
        repeat (40) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= en;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        hold_en = en;
    endtask

    initial begin
        hold_en = 0; armed = 0; ref_t = 0; visit_t = 0; span = 0;
        for (int i = 0; i < 3; i++) begin
            ref_v[i] = 0; start_v[i] = 0; last_v[i] = 0; slope[i] = 0;
        end
        clk_now = 0;
        clk_stamp = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // hold off: everything passes
        queue_item(MODE_UPDATE, 32'h0, 32'hFFFF_FFFF);
        queue_item(MODE_ACTIVATE, 32'h10, 32'h0);
        queue_item(2'd3, 32'hFFFF_FFFF, 32'h5);
        drain_and_set(1'b1);

        // directed: activate, lagged start, snap, hold, fast pass, wrap
        queue_item(MODE_UPDATE, 32'd5, 32'd0);
        queue_item(MODE_ACTIVATE, 32'd0, 32'd0);
        queue_item(MODE_UPDATE, 32'd1, 32'd100);
        queue_item(MODE_UPDATE, 32'd50, 32'd100);
        queue_item(MODE_UPDATE, 32'd199, 32'd100);
        queue_item(MODE_UPDATE, 32'd200, 32'd100);
        queue_item(MODE_UPDATE, 32'd210, 32'd100);
        queue_item(MODE_UPDATE, 32'd400, 32'd150);
        queue_item(MODE_UPDATE, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
        queue_item(MODE_UPDATE, 32'hFFFF_FFF1, 32'd2);
        queue_item(MODE_UPDATE, 32'h7FFF_FFFF, 32'd2);
        queue_item(MODE_UPDATE, 32'h7FFF_FFFF, 32'd2);
        queue_item(2'd3, 32'd0, 32'd0);
        queue_item(MODE_DEACTIVATE, 32'd0, 32'd0);
        queue_item(MODE_UPDATE, 32'd1, 32'd9);
        queue_item(MODE_ACTIVATE, 32'd0, 32'd0);
        queue_item(MODE_UPDATE, 32'd1, 32'd1);
        queue_item(MODE_UPDATE, 32'd2, 32'd1);

        // random phases, switching hold on and off
        for (int ph = 0; ph < 4; ph++) begin
            drain_and_set(ph != 2);
            clk_now = $urandom();
            clk_stamp = clk_now;
            queue_item(MODE_ACTIVATE, clk_now, clk_stamp);
            while (pending_items.size() < 180) begin
                if ($urandom_range(0, 9) == 0)
                    queue_item($urandom_range(0, 3), $urandom(), $urandom());
                else if ($urandom_range(0, 25) == 0)
                    queue_item($urandom_range(0, 2) == 0 ? MODE_DEACTIVATE : MODE_ACTIVATE,
                               clk_now, clk_stamp);
                else
                    queue_sample_run();
            end
        end

        wait (pending_items.size() == 0 && !s_tvalid && expected_outs.size() == 0);
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && expected_outs.size() == 0 && !timed_out)
            $display("[first_order_hold_vector_interp_core] OK");
        else
            $display("[first_order_hold_vector_interp_core] ERROR");
        $finish;
    end

    initial begin
        #20ms;
        timed_out = 1;
        $display("[first_order_hold_vector_interp_core] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+hdl
hdl/fohv_pkg.sv
hdl/fohv_ctrl.sv
hdl/fohv_dp.sv
hdl/first_order_hold_vector_interp_core.sv
hdl/fohv_chk.sv
verif/tb_first_order_hold_vector_interp_core.sv
